/* rtl/brfifo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// brfifo_pkg
// Shared types and constants of the byte ring FIFO.
// -----------------------------------------------------------------------------
package brfifo_pkg;

  // Default number of ring slots, one of which always stays empty
  localparam int DefaultDepth = 64;

  // Item and result field widths
  localparam int OpW    = 3;
  localparam int LenW   = 7;
  localparam int ByteW  = 8;
  localparam int CountW = 6;

  // Packed bus widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // Request codes; codes 5 to 7 are unused and get a refusal
  typedef enum logic [OpW-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_POP_ALL = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

endpackage
`default_nettype wire

/* rtl/byte_ring_fifo_all_or_nothing.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// byte_ring_fifo_all_or_nothing
// Byte ring FIFO with all-or-nothing push runs and pops, run by a small
// sequencer around one shared wrap-around pointer adder.
// -----------------------------------------------------------------------------
// A ring of DEPTH byte slots that holds at most DEPTH-1 bytes. Each input
// request carries an operation in tuser: push byte, pop, pop all, advance write
// pointer or clear. A push run is a series of push requests whose first one
// gives the run length; the run is taken only when that length is 1..DEPTH-1
// and fits the free space, bytes are staged in free slots as they arrive, and
// the write pointer moves only once the last byte of the run is in. Any other
// request ends an open run without moving the write pointer. A pop of n bytes
// is all or nothing; pop all drains every byte held. Every result carries the
// free space left after the whole request. The block works on one request at
// a time and holds s_axis_tready low until its last result has been taken:
// push (run not ending), advance, clear and unused codes go through accept,
// evaluate and result; a push that closes an accepted run makes one more
// pass through the shared adder to move the write pointer; and a pop of n
// bytes passes each byte through the single registered memory read port and
// then through the output register. A stall on m_axis_tready holds the
// result in place. Reset and clear empty the store at once through per-slot
// valid bits, so no clearing pass is needed.
// -----------------------------------------------------------------------------
module byte_ring_fifo_all_or_nothing #(
  parameter int DEPTH = brfifo_pkg::DefaultDepth
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Request side
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: length[6:0], data_byte[14:7], zero fill [15]
  input  wire  [brfifo_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: operation[2:0]
  input  wire  [brfifo_pkg::OpW-1:0]     s_axis_tuser,
  // Result side
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // tdata: accepted[0], data_out[8:1], byte_count[14:9], free_space[20:15],
  //        zero fill [23:21]
  output logic [brfifo_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: has_byte[0]
  output logic                           m_axis_tuser,
  // tlast: last result of this request
  output logic                           m_axis_tlast
);

  localparam int PW   = $clog2(DEPTH);
  localparam int LenW = brfifo_pkg::LenW;
  localparam int CntW = brfifo_pkg::CountW;
  localparam int BW   = brfifo_pkg::ByteW;

  localparam logic [LenW-1:0] DepthL   = LenW'(DEPTH);
  localparam logic [LenW-1:0] DepthM1L = LenW'(DEPTH - 1);
  localparam logic [LenW:0]   DepthS   = (LenW + 1)'(DEPTH);

  // One-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_COMMIT = 5'b00100,
    S_READ   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Latched request
  brfifo_pkg::op_e op_q;
  logic [LenW-1:0] len_q;
  logic [BW-1:0]   dat_q;

  // Ring pointers and slot valid bits
  logic [PW-1:0]    rp_q, rp_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [DEPTH-1:0] vld_q, vld_d;

  // Push run tracking
  logic            run_active_q, run_active_d;
  logic            run_ok_q, run_ok_d;
  logic [LenW-1:0] run_len_q, run_len_d;
  logic [LenW-1:0] run_off_q, run_off_d;

  // Result register and pop progress
  logic            acc_q, acc_d;
  logic            has_q, has_d;
  logic            last_q, last_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]   target_q, target_d;
  logic [LenW-1:0] pop_free_q, pop_free_d;

  // Byte store with registered read
  logic [BW-1:0] mem_q [DEPTH];
  logic [BW-1:0] rd_q;
  logic          rd_vld_q;
  logic          mem_we;

  // Shared wrap-around adder
  logic [PW-1:0]   wa_a;
  logic [LenW-1:0] wa_b;
  logic [LenW:0]   wa_s0, wa_s1;
  logic [PW-1:0]   wa_sum;

  // Occupancy
  logic [LenW-1:0] used_s, free_s;

  // Push run view for the current request
  logic            run_new;
  logic            eff_ok;
  logic [LenW-1:0] eff_len, eff_off, off_n, span;
  logic            run_done;

  logic in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Bytes held, counting around the ring
  always_comb begin
    if (wp_q >= rp_q) begin
      used_s = LenW'(wp_q) - LenW'(rp_q);
    end else begin
      used_s = LenW'(wp_q) + DepthL - LenW'(rp_q);
    end
    free_s = DepthM1L - used_s;
  end

  // A run opens on the first push seen while no run is open
  assign run_new  = !run_active_q;
  assign eff_len  = run_new ? len_q : run_len_q;
  assign eff_off  = run_new ? '0 : run_off_q;
  assign eff_ok   = run_new ? ((len_q != '0) && (len_q <= DepthM1L) && (len_q <= free_s))
                            : run_ok_q;
  assign off_n    = eff_off + LenW'(1);
  assign span     = (eff_len == '0) ? LenW'(1) : eff_len;
  assign run_done = (off_n >= span);

  // Operand select for the shared adder
  always_comb begin
    wa_a = wp_q;
    wa_b = '0;
    case (state_q)
      S_EVAL: begin
        if (op_q == brfifo_pkg::OP_ADVANCE) begin
          wa_b = len_q;
        end else begin
          wa_b = eff_off;
        end
      end
      S_COMMIT: begin
        wa_b = run_len_q;
      end
      S_READ: begin
        wa_a = rp_q;
        wa_b = LenW'(1);
      end
      default: begin
        wa_b = '0;
      end
    endcase
  end

  always_comb begin
    wa_s0 = (LenW + 1)'(wa_a) + {1'b0, wa_b};
    wa_s1 = (wa_s0 >= DepthS) ? (wa_s0 - DepthS) : wa_s0;
    wa_sum = (wa_s1 >= DepthS) ? '0 : wa_s1[PW-1:0];
  end

  assign mem_we = (state_q == S_EVAL) && (op_q == brfifo_pkg::OP_PUSH) && eff_ok;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    vld_d        = vld_q;
    run_active_d = run_active_q;
    run_ok_d     = run_ok_q;
    run_len_d    = run_len_q;
    run_off_d    = run_off_q;
    acc_d        = acc_q;
    has_d        = has_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    target_d     = target_q;
    pop_free_d   = pop_free_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        // Defaults: one closing result without a byte
        acc_d   = 1'b0;
        has_d   = 1'b0;
        last_d  = 1'b1;
        cnt_d   = '0;
        state_d = S_EMIT;
        if (op_q != brfifo_pkg::OP_PUSH) begin
          run_active_d = 1'b0;
        end
        case (op_q)
          brfifo_pkg::OP_PUSH: begin
            acc_d     = eff_ok;
            run_ok_d  = eff_ok;
            run_len_d = eff_len;
            run_off_d = off_n;
            if (eff_ok) begin
              vld_d[wa_sum] = 1'b1;
            end
            run_active_d = !run_done;
            if (run_done && eff_ok) begin
              state_d = S_COMMIT;
            end
          end
          brfifo_pkg::OP_POP: begin
            if ((len_q != '0) && (len_q <= DepthM1L) && (len_q <= used_s)) begin
              acc_d      = 1'b1;
              last_d     = 1'b0;
              target_d   = len_q[PW-1:0];
              pop_free_d = free_s + len_q;
              state_d    = S_READ;
            end
          end
          brfifo_pkg::OP_POP_ALL: begin
            acc_d = 1'b1;
            if (used_s != '0) begin
              last_d     = 1'b0;
              target_d   = used_s[PW-1:0];
              pop_free_d = DepthM1L;
              state_d    = S_READ;
            end
          end
          brfifo_pkg::OP_ADVANCE: begin
            if (len_q < DepthL) begin
              acc_d = 1'b1;
              wp_d  = wa_sum;
            end
          end
          brfifo_pkg::OP_CLEAR: begin
            acc_d = 1'b1;
            rp_d  = '0;
            wp_d  = '0;
            vld_d = '0;
          end
          default: begin
            acc_d = 1'b0;
          end
        endcase
      end

      S_COMMIT: begin
        // Close an accepted run: move the write pointer past it
        wp_d    = wa_sum;
        state_d = S_EMIT;
      end

      S_READ: begin
        // Fetch one byte and advance the read pointer
        rp_d    = wa_sum;
        cnt_d   = cnt_q + PW'(1);
        last_d  = ((cnt_q + PW'(1)) == target_q);
        has_d   = 1'b1;
        acc_d   = 1'b1;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (m_axis_tready) begin
          state_d = (has_q && !last_q) ? S_READ : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rp_q         <= '0;
      wp_q         <= '0;
      vld_q        <= '0;
      run_active_q <= 1'b0;
      run_ok_q     <= 1'b0;
      run_len_q    <= '0;
      run_off_q    <= '0;
      acc_q        <= 1'b0;
      has_q        <= 1'b0;
      last_q       <= 1'b0;
      cnt_q        <= '0;
      target_q     <= '0;
      pop_free_q   <= '0;
    end else begin
      state_q      <= state_d;
      rp_q         <= rp_d;
      wp_q         <= wp_d;
      vld_q        <= vld_d;
      run_active_q <= run_active_d;
      run_ok_q     <= run_ok_d;
      run_len_q    <= run_len_d;
      run_off_q    <= run_off_d;
      acc_q        <= acc_d;
      has_q        <= has_d;
      last_q       <= last_d;
      cnt_q        <= cnt_d;
      target_q     <= target_d;
      pop_free_q   <= pop_free_d;
    end
  end

  // Request latch, byte store and its registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= brfifo_pkg::op_e'(s_axis_tuser);
      len_q <= s_axis_tdata[LenW-1:0];
      dat_q <= s_axis_tdata[LenW+BW-1:LenW];
    end
    if (mem_we) begin
      mem_q[wa_sum] <= dat_q;
    end
    if (state_q == S_READ) begin
      rd_q     <= mem_q[rp_q];
      rd_vld_q <= vld_q[rp_q];
    end
  end

  // Ports
  logic [BW-1:0]   out_byte;
  logic [LenW-1:0] out_free;

  assign out_byte = (has_q && rd_vld_q) ? rd_q : '0;
  // Pops report the space after the whole pop; other requests are already final
  assign out_free = has_q ? pop_free_q : free_s;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign m_axis_tuser  = has_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {3'b000, CntW'(out_free), CntW'(cnt_q), out_byte, acc_q};

`ifndef SYNTH
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LenW'(rp_q) < DepthL) && (LenW'(wp_q) < DepthL))
    else $error("ring pointer beyond depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("new request taken while a result is pending");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && has_q) |-> ((cnt_q != '0) && (cnt_q <= target_q)))
    else $error("popped byte count out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_q) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after the last result");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring FIFO: drives push runs, pops, pop-all,
// write pointer advances, clears and spare codes, predicts every result of
// each accepted request and compares them field by field as they come out.
// -----------------------------------------------------------------------------
module testbench;
  import brfifo_pkg::*;

  localparam int Depth       = DefaultDepth;
  localparam int SlotMax     = Depth - 1;   // one slot always stays empty
  localparam int ItemTarget  = 370;
  localparam int CycleLimit  = 600000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;
  localparam int IdlePct     = 27;

  // Codes 5 to 7 carry no operation and get a refusal
  localparam logic [OpW-1:0] OpFirstSpare = 3'd5;
  localparam logic [OpW-1:0] OpLastSpare  = 3'd7;

  typedef struct packed {
    logic              accepted;
    logic              has_byte;
    logic [ByteW-1:0]  data_out;
    logic              last;
    logic [CountW-1:0] byte_count;
    logic [CountW-1:0] free_space;
  } fifo_result_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: own copy of the ring, predicts results per accepted request
  // ---------------------------------------------------------------------------
  class ring_fifo_scoreboard;
    logic [ByteW-1:0]  ring [Depth];
    logic [CountW-1:0] rd_ptr;
    logic [CountW-1:0] wr_ptr;
    logic              run_open;
    logic              run_ok;
    logic [LenW-1:0]   run_len;
    logic [LenW-1:0]   run_pos;
    fifo_result_t      pending_results[$];
    int                mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      rd_ptr     = '0;
      wr_ptr     = '0;
      run_open   = 1'b0;
      run_ok     = 1'b0;
      run_len    = '0;
      run_pos    = '0;
      mismatches = 0;
    endfunction

    function int used_slots();
      logic [CountW-1:0] diff;
      diff = wr_ptr - rd_ptr;
      return int'(diff);
    endfunction

    function fifo_result_t one_result(logic acc, logic hb, logic [ByteW-1:0] d,
                                      logic lst, logic [CountW-1:0] cnt);
      fifo_result_t r;
      r.accepted   = acc;
      r.has_byte   = hb;
      r.data_out   = d;
      r.last       = lst;
      r.byte_count = cnt;
      r.free_space = '0;
      return r;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [LenW-1:0] len,
                               logic [ByteW-1:0] dat);
      fifo_result_t      step[$];
      logic [CountW-1:0] slot;
      logic [CountW-1:0] fs;
      int                n;
      int                span;
      // Any other request closes an open push run without moving wr_ptr
      if (op != OP_PUSH) run_open = 1'b0;
      case (op)
        OP_PUSH: begin
          if (!run_open) begin
            run_open = 1'b1;
            run_len  = len;
            run_pos  = '0;
            run_ok   = (len >= 1) && (int'(len) <= SlotMax) &&
                       (int'(len) <= SlotMax - used_slots());
          end
          if (run_ok) begin
            slot       = wr_ptr + run_pos[CountW-1:0];
            ring[slot] = dat;
          end
          run_pos = run_pos + 1'b1;
          span    = (run_len != 0) ? int'(run_len) : 1;
          if (int'(run_pos) >= span) begin
            if (run_ok) wr_ptr = wr_ptr + run_len[CountW-1:0];
            run_open = 1'b0;
          end
          step.push_back(one_result(run_ok, 1'b0, '0, 1'b1, '0));
        end
        OP_POP, OP_POP_ALL: begin
          if (op == OP_POP_ALL) n = used_slots();
          else if (len >= 1 && int'(len) <= SlotMax && int'(len) <= used_slots()) n = int'(len);
          else n = 0;
          for (int i = 1; i <= n; i++) begin
            step.push_back(one_result(1'b1, 1'b1, ring[rd_ptr], i == n, CountW'(i)));
            rd_ptr = rd_ptr + 1'b1;
          end
          // Empty pop-all is still a success; a refused pop is not
          if (n == 0) step.push_back(one_result(op == OP_POP_ALL, 1'b0, '0, 1'b1, '0));
        end
        OP_ADVANCE: begin
          if (int'(len) < Depth) wr_ptr = wr_ptr + len[CountW-1:0];
          step.push_back(one_result(int'(len) < Depth, 1'b0, '0, 1'b1, '0));
        end
        OP_CLEAR: begin
          foreach (ring[i]) ring[i] = '0;
          rd_ptr = '0;
          wr_ptr = '0;
          step.push_back(one_result(1'b1, 1'b0, '0, 1'b1, '0));
        end
        default: step.push_back(one_result(1'b0, 1'b0, '0, 1'b1, '0));
      endcase
      // Free space is taken after the whole request, same in every result
      fs = CountW'(SlotMax - used_slots());
      foreach (step[i]) begin
        step[i].free_space = fs;
        pending_results.push_back(step[i]);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(fifo_result_t got);
      fifo_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %p with nothing pending", got));
      end else begin
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0b, want %0b", got.accepted, want.accepted));
        if (got.has_byte !== want.has_byte)
          report_mismatch($sformatf("has_byte %0b, want %0b", got.has_byte, want.has_byte));
        if (got.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %02h, want %02h", got.data_out, want.data_out));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        if (got.byte_count !== want.byte_count)
          report_mismatch($sformatf("byte_count %0d, want %0d", got.byte_count,
                                    want.byte_count));
        if (got.free_space !== want.free_space)
          report_mismatch($sformatf("free_space %0d, want %0d", got.free_space,
                                    want.free_space));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  ring_fifo_scoreboard board;
  int                  items_sent;
  bit                  idle_on;      // random gaps on both sides
  bit                  rx_hold_req;  // ask the receiver for a long hold-off
  int                  hold_left;

  byte_ring_fifo_all_or_nothing dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: far above the slowest legal run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: drive tready at the falling edge, sample at the rising edge
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        // Hold off so the block backs up and stalls the request side
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    fifo_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      // Unpack tdata: accepted, data_out, byte_count, free_space from bit 0 up
      got.accepted   = m_axis_tdata[0];
      got.data_out   = m_axis_tdata[8:1];
      got.byte_count = m_axis_tdata[14:9];
      got.free_space = m_axis_tdata[20:15];
      got.has_byte   = m_axis_tuser;
      got.last       = m_axis_tlast;
      board.check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request, with random gaps ahead of it, and note it once taken
  task automatic send_request(input logic [OpW-1:0] op, input logic [LenW-1:0] len,
                              input logic [ByteW-1:0] dat);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, dat, len};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(op, len, dat);
    items_sent++;
  endtask

  // Send n push requests; only the first length counts, the rest is noise
  task automatic push_run(input int run_len, input int n);
    for (int i = 0; i < n; i++)
      send_request(OP_PUSH, (i == 0) ? LenW'(run_len) : LenW'($urandom_range(127)),
                   ByteW'($urandom_range(255)));
  endtask

  // Drop the request offer, then hold until every predicted result is out
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random mix: mostly well-formed push runs, with pops to keep the ring moving
  task automatic random_request();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 50) begin
      len = ($urandom_range(99) < 4) ? $urandom_range(20, SlotMax) : $urandom_range(1, 8);
      push_run(len, len);
    end else if (pick < 56) begin
      // Break a run off early, then end it with a pop
      len = $urandom_range(2, 12);
      push_run(len, $urandom_range(1, len - 1));
      send_request(OP_POP, LenW'($urandom_range(1, 6)), ByteW'($urandom_range(255)));
    end else if (pick < 59) begin
      // Lengths that can never be taken: zero or beyond the ring
      len = $urandom_range(1) ? 0 : $urandom_range(Depth, 127);
      if (len == 0) push_run(0, 1);
      else push_run(len, ($urandom_range(19) == 0) ? len : $urandom_range(1, 4));
    end else if (pick < 74) begin
      len = ($urandom_range(99) < 6) ? $urandom_range(127) : $urandom_range(1, 10);
      send_request(OP_POP, LenW'(len), ByteW'($urandom_range(255)));
    end else if (pick < 83) begin
      send_request(OP_POP_ALL, LenW'($urandom_range(127)), ByteW'($urandom_range(255)));
    end else if (pick < 91) begin
      len = ($urandom_range(99) < 20) ? $urandom_range(Depth, 127) : $urandom_range(0, 6);
      send_request(OP_ADVANCE, LenW'(len), ByteW'($urandom_range(255)));
    end else if (pick < 95) begin
      send_request(OP_CLEAR, LenW'($urandom_range(127)), ByteW'($urandom_range(255)));
    end else begin
      send_request(OpW'($urandom_range(OpLastSpare, OpFirstSpare)),
                   LenW'($urandom_range(127)), ByteW'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit held;
    bit paused;
    board         = new();
    items_sent    = 0;
    idle_on       = 1'b1;
    rx_hold_req   = 1'b0;
    held          = 1'b0;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PUSH;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty ring, refused lengths, aborts, spare codes, full ring
    send_request(OP_POP_ALL, 7'd0, 8'h00);         // empty pop-all still succeeds
    send_request(OP_POP, 7'd1, 8'h00);             // pop from empty: refused
    push_run(0, 1);                                // zero-length run: one refused item
    send_request(OP_PUSH, 7'd3, 8'h00);
    send_request(OP_PUSH, 7'd0, 8'hFF);
    send_request(OP_PUSH, 7'd127, 8'h5A);
    send_request(OP_POP, 7'd0, 8'hFF);             // zero-byte pop: refused
    send_request(OP_POP, 7'd64, 8'h00);            // beyond the ring: refused
    send_request(OP_POP, 7'd127, 8'h00);
    send_request(OP_POP, 7'd2, 8'h00);
    send_request(OP_POP_ALL, 7'd127, 8'hFF);
    send_request(OP_PUSH, 7'd4, 8'hC3);            // run cut short by a spare code
    send_request(OP_PUSH, 7'd0, 8'h3C);
    send_request(OpFirstSpare, 7'd5, 8'h11);
    send_request(OpFirstSpare + 3'd1, 7'd0, 8'h00);
    send_request(OpLastSpare, 7'd127, 8'hFF);
    send_request(OP_ADVANCE, 7'd64, 8'h00);        // offset too large: refused
    send_request(OP_ADVANCE, 7'd0, 8'h00);
    send_request(OP_ADVANCE, 7'd63, 8'h00);        // ring now full of old slots
    send_request(OP_PUSH, 7'd1, 8'hAA);            // no room: refused
    send_request(OP_POP_ALL, 7'd0, 8'h00);         // drain all 63 bytes
    send_request(OP_CLEAR, 7'd0, 8'h00);

    // Random part, with one long receiver hold-off and one full drain
    while (items_sent < ItemTarget) begin
      if (!held && items_sent >= 120) begin
        rx_hold_req = 1'b1;
        held        = 1'b1;
      end
      if (!paused && items_sent >= 270) begin
        wait_for_results();
        paused = 1'b1;
      end
      // Run flat out for a stretch on both sides
      idle_on = !(items_sent >= 170 && items_sent < 250);
      random_request();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
